// ===== rtl/core/o2mcc_pkg.sv =====
package o2mcc_pkg;

	// Widths of the configuration port.
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	// Throttle rate, and the period in milliseconds that follows from it.
	localparam int unsigned RATE_W      = 10;
	localparam int unsigned MS_PER_S    = 1000;
	localparam int unsigned RATE_RESET  = 100;
	localparam int unsigned PERIOD_RESET = MS_PER_S / RATE_RESET;
	localparam int unsigned DIV_CNT_W   = $clog2(RATE_W + 1);

	// Value slots and messages per sample.
	localparam int unsigned NUM_SLOTS   = 4;
	localparam int unsigned NUM_MSGS    = 2 * NUM_SLOTS;
	localparam int unsigned VAL_W       = 14;

	// Control change status nibble and the offset of a fine (LSB) controller.
	localparam logic [3:0] STATUS_CC   = 4'hB;
	localparam logic [6:0] CC_LSB_OFFS = 7'd32;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_EULER7  = 2'd1,
		MODE_EULER14 = 2'd2,
		MODE_QUAT    = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OUTPUT_MODE      = 3'd0,
		REG_RATE_HZ          = 3'd1,
		REG_CHANNEL_NUMBER   = 3'd2,
		REG_YAW_CONTROLLER   = 3'd3,
		REG_PITCH_CONTROLLER = 3'd4,
		REG_ROLL_CONTROLLER  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic        [31:0] time_ms;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] roll_angle;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} sample_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [6:0] controller_byte;
		logic [6:0] value_byte;
		logic       last_message;
	} msg_t;

endpackage

// ===== rtl/core/o2mcc_period_div.sv =====
// Restoring divider that works out the throttle period as one second in
// milliseconds divided by the rate, one quotient bit per cycle.
module o2mcc_period_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [o2mcc_pkg::RATE_W-1:0]   rate,
	output logic                           busy,
	output logic [o2mcc_pkg::RATE_W-1:0]   period
);

	localparam int unsigned W = o2mcc_pkg::RATE_W;

	logic [W-1:0]                        divisor_q;
	logic [W-1:0]                        dvd_q;
	logic [W-1:0]                        rem_q;
	logic [W-1:0]                        quo_q;
	logic [W-1:0]                        period_q;
	logic [o2mcc_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic                                busy_q;

	logic [W:0] rem_sh;
	logic [W:0] rem_sub;
	logic       ge;

	always_comb begin
		rem_sh  = {rem_q, dvd_q[W-1]};
		ge      = rem_sh >= {1'b0, divisor_q};
		rem_sub = rem_sh - {1'b0, divisor_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			period_q <= W'(o2mcc_pkg::PERIOD_RESET);
		end else if (start) begin
			// A rate of zero turns throttling off: period zero, no division.
			if (rate == '0) begin
				busy_q   <= 1'b0;
				period_q <= '0;
			end else begin
				busy_q <= 1'b1;
			end
			cnt_q <= o2mcc_pkg::DIV_CNT_W'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == o2mcc_pkg::DIV_CNT_W'(1)) begin
				busy_q   <= 1'b0;
				period_q <= {quo_q[W-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= rate;
			dvd_q     <= W'(o2mcc_pkg::MS_PER_S);
			rem_q     <= '0;
			quo_q     <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[W-2:0], 1'b0};
			rem_q <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign busy   = busy_q;
	assign period = period_q;

endmodule

// ===== rtl/core/orientation_to_midi_cc_top.sv =====
// Orientation to MIDI control change encoder. Each sample transfer carries a
// millisecond time, yaw, pitch and roll as binary angles and a Q1.14
// quaternion; the block maps them according to the configured output mode,
// compares the results with the values it last sent, and emits a control
// change message (status, controller, value) for every changed value, the
// fine LSB controller (base plus 32) before the coarse MSB controller in the
// 14-bit modes, with last_message set on the final message of a sample.
// Samples arriving less than 1000/rate_hz milliseconds after the last
// accepted one are dropped without output. A sample is registered on entry
// and evaluated once the divider is idle and no messages are left, so
// samples that produce none flow at one per cycle while neither holds
// them; one that produces messages holds the input until its last one
// enters the output register, one per cycle while msg_stall is low. A
// non-zero rate_hz write makes a bit-serial divider recompute the period
// with sample_stall high; a rate of zero takes effect at once. cfg_ready is
// always high; configuration is meant to be written while the block is idle.
module orientation_to_midi_cc_top (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  o2mcc_pkg::sample_t                  sample,

	output logic                                msg_valid,
	input  logic                                msg_stall,
	output o2mcc_pkg::msg_t                     msg,

	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [o2mcc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [o2mcc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned NS = o2mcc_pkg::NUM_SLOTS;
	localparam int unsigned NM = o2mcc_pkg::NUM_MSGS;
	localparam int unsigned VW = o2mcc_pkg::VAL_W;

	// Maps a Q1.14 component to 0..16383: clamp c+16384 to 0..32768, then
	// scale by 16383/32768 with the multiply written as a shift and subtract.
	function automatic logic [VW-1:0] quat_map(input logic signed [15:0] c);
		logic signed [16:0] t;
		logic        [15:0] tc;
		logic        [29:0] prod;
		t = {c[15], c} + 17'sd16384;
		if (t < 17'sd0) begin
			tc = 16'd0;
		end else if (t > 17'sd32768) begin
			tc = 16'd32768;
		end else begin
			tc = t[15:0];
		end
		prod = {tc, 14'd0} - {14'd0, tc};
		return prod[28:15];
	endfunction

	// Configuration registers. The rate itself lives only in the divider.
	o2mcc_pkg::mode_t                 mode_q;
	logic [4:0]                       chan_q;
	logic [6:0]                       yaw_cc_q;
	logic [6:0]                       pitch_cc_q;
	logic [6:0]                       roll_cc_q;

	logic                             div_start;
	logic                             div_busy;
	logic [o2mcc_pkg::RATE_W-1:0]     period;

	// Input register.
	logic                             valid_s1;
	o2mcc_pkg::sample_t               sample_s1;

	// Encoder state.
	logic [VW-1:0]                    prev_q [NS];
	logic [31:0]                      last_time_q;
	logic                             has_sent_q;

	// Pending messages of the sample last evaluated.
	logic [NM-1:0]                    pend_q;
	logic [VW-1:0]                    val_q [NS];
	logic                             is7_q;

	// Output register.
	logic                             msg_valid_q;
	o2mcc_pkg::msg_t                  msg_q;

	// Evaluation of the registered sample.
	logic [VW-1:0]                    v [NS];
	logic [NS-1:0]                    chg;
	logic [NS-1:0]                    send;
	logic [NM-1:0]                    mask;
	logic [31:0]                      elapsed;
	logic                             throttled;
	logic                             blocked;
	logic                             proc_fire;
	logic                             take;

	// Message selection.
	logic [$clog2(NM)-1:0]            sel;
	logic [NM-1:0]                    sel_oh;
	logic [NM-1:0]                    pend_left;
	logic                             pop;
	logic                             buf_free;
	logic [1:0]                       slot;
	logic                             is_msb;
	logic [6:0]                       cc_base;
	logic [6:0]                       cc_sel;
	logic [6:0]                       val_sel;

	assign cfg_ready = 1'b1;
	assign div_start = cfg_valid && cfg_index == o2mcc_pkg::REG_RATE_HZ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= o2mcc_pkg::MODE_OFF;
			chan_q     <= 5'd1;
			yaw_cc_q   <= 7'd16;
			pitch_cc_q <= 7'd17;
			roll_cc_q  <= 7'd18;
		end else if (cfg_valid) begin
			case (o2mcc_pkg::cfg_reg_t'(cfg_index))
				o2mcc_pkg::REG_OUTPUT_MODE:      mode_q     <= o2mcc_pkg::mode_t'(cfg_data[1:0]);
				o2mcc_pkg::REG_RATE_HZ:          ;
				o2mcc_pkg::REG_CHANNEL_NUMBER:   chan_q     <= cfg_data[4:0];
				o2mcc_pkg::REG_YAW_CONTROLLER:   yaw_cc_q   <= cfg_data[6:0];
				o2mcc_pkg::REG_PITCH_CONTROLLER: pitch_cc_q <= cfg_data[6:0];
				o2mcc_pkg::REG_ROLL_CONTROLLER:  roll_cc_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// The divider samples the rate from the port directly, so it starts in
	// the cycle of the write.
	o2mcc_period_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rate   (cfg_data[o2mcc_pkg::RATE_W-1:0]),
		.busy   (div_busy),
		.period (period)
	);

	// Selection of the next pending message: lowest set bit first, which
	// gives the slot order and LSB before MSB within a slot.
	always_comb begin
		sel = '0;
		for (int i = NM - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				sel = ($clog2(NM))'(i);
			end
		end
		sel_oh    = NM'(1) << sel;
		pend_left = pend_q & ~sel_oh;
		pop       = (pend_q != '0) && (!msg_valid_q || !msg_stall);
		buf_free  = pop ? (pend_left == '0) : (pend_q == '0);
		slot      = sel[2:1];
		is_msb    = sel[0];
	end

	always_comb begin
		if (mode_q == o2mcc_pkg::MODE_QUAT) begin
			cc_base = yaw_cc_q + {5'd0, slot};
		end else begin
			case (slot)
				2'd0:    cc_base = yaw_cc_q;
				2'd1:    cc_base = pitch_cc_q;
				default: cc_base = roll_cc_q;
			endcase
		end
		// The first message of a 14-bit value goes to the fine controller.
		cc_sel  = (!is7_q && !is_msb) ? cc_base + o2mcc_pkg::CC_LSB_OFFS : cc_base;
		val_sel = is_msb ? val_q[slot][13:7] : val_q[slot][6:0];
	end

	// Evaluation of the registered sample against the stored state.
	always_comb begin
		v[0] = '0;
		v[1] = '0;
		v[2] = '0;
		v[3] = '0;
		case (mode_q)
			o2mcc_pkg::MODE_EULER7: begin
				v[0] = {7'd0, ~sample_s1.yaw_angle[15], sample_s1.yaw_angle[14:9]};
				v[1] = {7'd0, ~sample_s1.pitch_angle[15], sample_s1.pitch_angle[14:9]};
				v[2] = {7'd0, ~sample_s1.roll_angle[15], sample_s1.roll_angle[14:9]};
			end
			o2mcc_pkg::MODE_EULER14: begin
				v[0] = {~sample_s1.yaw_angle[15], sample_s1.yaw_angle[14:2]};
				v[1] = {~sample_s1.pitch_angle[15], sample_s1.pitch_angle[14:2]};
				v[2] = {~sample_s1.roll_angle[15], sample_s1.roll_angle[14:2]};
			end
			o2mcc_pkg::MODE_QUAT: begin
				v[0] = quat_map(sample_s1.quat_w);
				v[1] = quat_map(sample_s1.quat_x);
				v[2] = quat_map(sample_s1.quat_y);
				v[3] = quat_map(sample_s1.quat_z);
			end
			default: ;
		endcase

		for (int i = 0; i < NS; i++) begin
			chg[i]  = !has_sent_q || (v[i] != prev_q[i]);
			// The fourth slot is only ever sent in quaternion mode.
			send[i] = chg[i] && (i < NS - 1 || mode_q == o2mcc_pkg::MODE_QUAT);
			mask[2*i]     = send[i];
			mask[2*i + 1] = send[i] && mode_q != o2mcc_pkg::MODE_EULER7;
		end

		elapsed   = sample_s1.time_ms - last_time_q;
		throttled = has_sent_q && (elapsed < {22'd0, period});
		blocked   = mode_q == o2mcc_pkg::MODE_OFF || throttled || (has_sent_q && chg == '0);
		proc_fire = valid_s1 && !div_busy && buf_free;
		take      = proc_fire && !blocked;
	end

	assign sample_stall = div_busy || (valid_s1 && !proc_fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_valid && !sample_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
	end

	// State update and loading of the message set. A sample that is
	// accepted but sends nothing (only the unused fourth slot differs in an
	// Euler mode) still moves the time stamp and primes the encoder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) begin
				prev_q[i] <= '0;
			end
			last_time_q <= '0;
			has_sent_q  <= 1'b0;
			pend_q      <= '0;
		end else if (take) begin
			for (int i = 0; i < NS; i++) begin
				if (send[i]) begin
					prev_q[i] <= v[i];
				end
			end
			last_time_q <= sample_s1.time_ms;
			has_sent_q  <= 1'b1;
			pend_q      <= mask;
		end else if (pop) begin
			pend_q <= pend_left;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < NS; i++) begin
				val_q[i] <= v[i];
			end
			is7_q <= mode_q == o2mcc_pkg::MODE_EULER7;
		end
	end

	// Output register: one message per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid_q <= 1'b0;
		end else if (pop) begin
			msg_valid_q <= 1'b1;
		end else if (!msg_stall) begin
			msg_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			msg_q.status_byte     <= {o2mcc_pkg::STATUS_CC, chan_q[3:0] - 4'd1};
			msg_q.controller_byte <= cc_sel;
			msg_q.value_byte      <= val_sel;
			msg_q.last_message    <= pend_left == '0;
		end
	end

	assign msg_valid = msg_valid_q;
	assign msg       = msg_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	// Cycles allowed for the block to finish a sample that yields no message, before the
	// bench treats it as idle.
	localparam int unsigned SETTLE_CYCLES   = 20;
	// Length of the deliberate receiver hold-off that backs the block up.
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	// Samples that reach the encoder (not throttled, not unchanged) per random phase.
	localparam int unsigned PHASE_GOAL      = 20;

	logic                              clk;
	logic                              arst_n       = 1'b0;
	logic                              sample_valid = 1'b0;
	logic                              sample_stall;
	o2mcc_pkg::sample_t                sample       = '0;
	logic                              msg_valid;
	logic                              msg_stall    = 1'b0;
	o2mcc_pkg::msg_t                   msg;
	logic                              cfg_valid    = 1'b0;
	logic                              cfg_ready;
	logic [o2mcc_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
	logic [o2mcc_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

	// Shadow copy of the configuration, updated as each register write is taken.
	o2mcc_pkg::mode_t mode_cfg    = o2mcc_pkg::MODE_OFF;
	logic [31:0]      throttle_ms = o2mcc_pkg::PERIOD_RESET;
	logic [4:0]       channel_cfg = 5'd1;
	logic [6:0]       yaw_cc      = 7'd16;
	logic [6:0]       pitch_cc    = 7'd17;
	logic [6:0]       roll_cc     = 7'd18;

	// Shadow copy of the encoder state.
	logic [o2mcc_pkg::VAL_W-1:0] prev_sent [o2mcc_pkg::NUM_SLOTS] = '{default: '0};
	logic [31:0]                 sent_time_ms    = '0;
	logic                        primed          = 1'b0;
	int                          samples_encoded = 0;

	// Control change messages still owed by the block, oldest first, and samples not yet
	// offered to it.
	o2mcc_pkg::msg_t    cc_expected [$];
	o2mcc_pkg::sample_t pending_samples [$];

	int error_count = 0;

	// Bookkeeping shared between the processes; every counter has a single writer.
	int samples_accepted  = 0;
	int samples_driven    = 0;
	int send_gap_left     = 0;
	int send_burst_left   = 0;
	int stall_left        = 0;
	int free_left         = 0;
	int hold_off_left     = 0;
	int hold_off_requests = 0;
	int hold_off_served   = 0;

	// State of the random sample generator.
	logic [31:0]        gen_time = '0;
	o2mcc_pkg::sample_t gen_prev = '0;

	orientation_to_midi_cc_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.msg_valid    (msg_valid),
		.msg_stall    (msg_stall),
		.msg          (msg),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Appends one control change message for the current channel to the expected stream.
	function automatic void push_cc(input logic [6:0] cc, input logic [6:0] val);
		o2mcc_pkg::msg_t m;
		m.status_byte     = {o2mcc_pkg::STATUS_CC, channel_cfg[3:0] - 4'd1};
		m.controller_byte = cc;
		m.value_byte      = val;
		m.last_message    = 1'b0;
		cc_expected.push_back(m);
	endfunction

	// Works out the messages that one accepted sample causes and advances the shadow state.
	task automatic encode_sample(input o2mcc_pkg::sample_t s);
		logic [31:0]                 elapsed;
		logic [15:0]                 angle [3];
		logic [15:0]                 comp [o2mcc_pkg::NUM_SLOTS];
		logic [o2mcc_pkg::VAL_W-1:0] slot_val [o2mcc_pkg::NUM_SLOTS];
		logic                        slot_new [o2mcc_pkg::NUM_SLOTS];
		logic [6:0]                  cc_num [3];
		logic [6:0]                  base;
		logic                        any_new;
		int                          t;
		int                          first_idx;

		elapsed = s.time_ms - sent_time_ms;
		if (mode_cfg == o2mcc_pkg::MODE_OFF) begin
			return;
		end
		// The time compare is done modulo 2^32, so a wrap of the millisecond counter is
		// just another short interval.
		if (primed && elapsed < throttle_ms) begin
			return;
		end

		angle[0] = s.yaw_angle;
		angle[1] = s.pitch_angle;
		angle[2] = s.roll_angle;
		comp[0]  = s.quat_w;
		comp[1]  = s.quat_x;
		comp[2]  = s.quat_y;
		comp[3]  = s.quat_z;
		for (int i = 0; i < o2mcc_pkg::NUM_SLOTS; i++) begin
			slot_val[i] = '0;
		end

		case (mode_cfg)
			o2mcc_pkg::MODE_EULER7: begin
				// Flipping the sign bit adds half a turn, giving an offset binary angle.
				for (int i = 0; i < 3; i++) begin
					slot_val[i] = 14'((angle[i] ^ 16'h8000) >> 9);
				end
			end
			o2mcc_pkg::MODE_EULER14: begin
				for (int i = 0; i < 3; i++) begin
					slot_val[i] = 14'((angle[i] ^ 16'h8000) >> 2);
				end
			end
			default: begin
				for (int i = 0; i < o2mcc_pkg::NUM_SLOTS; i++) begin
					t = int'($signed(comp[i])) + 16384;
					if (t < 0) begin
						t = 0;
					end
					if (t > 32768) begin
						t = 32768;
					end
					slot_val[i] = 14'((t * 16383) >> 15);
				end
			end
		endcase

		// In the Euler modes the fourth slot is zero; a non-zero value left over from
		// quaternion mode still counts as a change although it is never sent.
		any_new = 1'b0;
		for (int i = 0; i < o2mcc_pkg::NUM_SLOTS; i++) begin
			slot_new[i] = !primed || (slot_val[i] != prev_sent[i]);
			any_new     = any_new | slot_new[i];
		end
		if (!any_new) begin
			return;
		end

		first_idx = cc_expected.size();
		if (mode_cfg == o2mcc_pkg::MODE_QUAT) begin
			for (int i = 0; i < o2mcc_pkg::NUM_SLOTS; i++) begin
				if (slot_new[i]) begin
					base = yaw_cc + 7'(i);
					push_cc(base + o2mcc_pkg::CC_LSB_OFFS, slot_val[i][6:0]);
					push_cc(base, slot_val[i][13:7]);
					prev_sent[i] = slot_val[i];
				end
			end
		end else begin
			cc_num[0] = yaw_cc;
			cc_num[1] = pitch_cc;
			cc_num[2] = roll_cc;
			for (int i = 0; i < 3; i++) begin
				if (slot_new[i]) begin
					if (mode_cfg == o2mcc_pkg::MODE_EULER7) begin
						push_cc(cc_num[i], slot_val[i][6:0]);
					end else begin
						push_cc(cc_num[i] + o2mcc_pkg::CC_LSB_OFFS, slot_val[i][6:0]);
						push_cc(cc_num[i], slot_val[i][13:7]);
					end
					prev_sent[i] = slot_val[i];
				end
			end
		end
		if (cc_expected.size() > first_idx) begin
			cc_expected[cc_expected.size() - 1].last_message = 1'b1;
		end

		sent_time_ms = s.time_ms;
		primed       = 1'b1;
		samples_encoded++;
	endtask

	// Every sample transfer is fed to the shadow encoder at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && sample_valid && !sample_stall) begin
			encode_sample(sample);
			samples_accepted++;
		end
	end

	// Sample driver. A new payload is presented only once the previous one has been
	// transferred, after a random gap; otherwise valid and payload are held.
	always @(negedge clk) begin : drive_samples
		logic               next_valid;
		o2mcc_pkg::sample_t next_sample;
		next_valid  = sample_valid;
		next_sample = sample;
		if (arst_n && (!sample_valid || samples_accepted != samples_driven)) begin
			samples_driven = samples_accepted;
			next_valid     = 1'b0;
			if (send_gap_left > 0) begin
				send_gap_left--;
			end else if (pending_samples.size() > 0) begin
				next_sample = pending_samples.pop_front();
				next_valid  = 1'b1;
				// Now and then a burst of back-to-back transfers with no gaps at all.
				if (send_burst_left > 0) begin
					send_burst_left--;
					send_gap_left = 0;
				end else if ($urandom_range(0, 15) == 0) begin
					send_burst_left = $urandom_range(10, 30);
					send_gap_left   = 0;
				end else begin
					send_gap_left = pick_gap();
				end
			end
		end
		sample_valid <= next_valid;
		sample       <= next_sample;
	end

	// Receiver stall. A requested hold-off takes priority and holds the stall for its full
	// length; otherwise random stalls alternate with stretches of free flow.
	always @(negedge clk) begin : drive_stall
		logic next_stall;
		next_stall = 1'b0;
		if (hold_off_left > 0) begin
			hold_off_left--;
			next_stall = 1'b1;
		end else if (hold_off_served != hold_off_requests) begin
			hold_off_served = hold_off_requests;
			hold_off_left   = HOLD_OFF_CYCLES - 1;
			next_stall      = 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			next_stall = 1'b1;
		end else if (free_left > 0) begin
			free_left--;
		end else if ($urandom_range(0, 19) == 0) begin
			free_left = $urandom_range(30, 80);
		end else begin
			stall_left = pick_gap();
		end
		msg_stall <= next_stall;
	end

	// Message checker: every transfer is compared, field by field, with the oldest
	// outstanding expectation.
	always @(posedge clk) begin : check_messages
		o2mcc_pkg::msg_t want;
		if (arst_n && msg_valid && !msg_stall) begin
			if (cc_expected.size() == 0) begin
				$error("unexpected message: status_byte %0h controller_byte %0d value_byte %0d",
					msg.status_byte, msg.controller_byte, msg.value_byte);
				error_count++;
			end else begin
				want = cc_expected.pop_front();
				if (msg.status_byte !== want.status_byte) begin
					$error("status_byte: expected %0h, got %0h", want.status_byte,
						msg.status_byte);
					error_count++;
				end
				if (msg.controller_byte !== want.controller_byte) begin
					$error("controller_byte: expected %0d, got %0d", want.controller_byte,
						msg.controller_byte);
					error_count++;
				end
				if (msg.value_byte !== want.value_byte) begin
					$error("value_byte: expected %0d, got %0d", want.value_byte,
						msg.value_byte);
					error_count++;
				end
				if (msg.last_message !== want.last_message) begin
					$error("last_message: expected %0b, got %0b", want.last_message,
						msg.last_message);
					error_count++;
				end
			end
		end
	end

	// One register write; the shadow copy follows at the edge of the transfer. Valid is
	// left high so that consecutive writes run back to back.
	task automatic write_reg(input o2mcc_pkg::cfg_reg_t idx,
			input logic [o2mcc_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			o2mcc_pkg::REG_OUTPUT_MODE: begin
				mode_cfg = o2mcc_pkg::mode_t'(data[1:0]);
			end
			o2mcc_pkg::REG_RATE_HZ: begin
				throttle_ms = (data == '0) ? 32'd0 : o2mcc_pkg::MS_PER_S / data;
			end
			o2mcc_pkg::REG_CHANNEL_NUMBER: begin
				channel_cfg = data[4:0];
			end
			o2mcc_pkg::REG_YAW_CONTROLLER: begin
				yaw_cc = data[6:0];
			end
			o2mcc_pkg::REG_PITCH_CONTROLLER: begin
				pitch_cc = data[6:0];
			end
			o2mcc_pkg::REG_ROLL_CONTROLLER: begin
				roll_cc = data[6:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	task automatic apply_setting(input o2mcc_pkg::mode_t mode, input logic [9:0] rate,
			input logic [4:0] chan, input logic [6:0] yaw, input logic [6:0] pitch,
			input logic [6:0] roll);
		write_reg(o2mcc_pkg::REG_OUTPUT_MODE, o2mcc_pkg::CFG_DATA_W'(mode));
		write_reg(o2mcc_pkg::REG_RATE_HZ, o2mcc_pkg::CFG_DATA_W'(rate));
		write_reg(o2mcc_pkg::REG_CHANNEL_NUMBER, o2mcc_pkg::CFG_DATA_W'(chan));
		write_reg(o2mcc_pkg::REG_YAW_CONTROLLER, o2mcc_pkg::CFG_DATA_W'(yaw));
		write_reg(o2mcc_pkg::REG_PITCH_CONTROLLER, o2mcc_pkg::CFG_DATA_W'(pitch));
		write_reg(o2mcc_pkg::REG_ROLL_CONTROLLER, o2mcc_pkg::CFG_DATA_W'(roll));
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_sample(input logic [31:0] now, input int yaw, input int pitch,
			input int roll, input int qw, input int qx, input int qy, input int qz);
		o2mcc_pkg::sample_t s;
		s.time_ms     = now;
		s.yaw_angle   = 16'(yaw);
		s.pitch_angle = 16'(pitch);
		s.roll_angle  = 16'(roll);
		s.quat_w      = 16'(qw);
		s.quat_x      = 16'(qx);
		s.quat_y      = 16'(qy);
		s.quat_z      = 16'(qz);
		pending_samples.push_back(s);
	endtask

	// Polled at the rising edge, where neither the driver nor the shadow encoder can be
	// caught half way through a transfer; ends on a falling edge, ready to drive.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_samples.size() != 0 || sample_valid || cc_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [15:0] next_angle(input logic [15:0] old);
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return old;
		end else if (r < 55) begin
			return old + 16'($urandom_range(0, 1200)) - 16'd600;
		end
		return 16'($urandom);
	endfunction

	// Mostly unit quaternion range, a few components well outside it to hit the clamp.
	function automatic logic [15:0] next_quat(input logic [15:0] old);
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) begin
			return old;
		end else if (r < 40) begin
			return old + 16'($urandom_range(0, 600)) - 16'd300;
		end else if (r < 90) begin
			return 16'($urandom_range(0, 32768)) - 16'd16384;
		end
		return 16'($urandom);
	endfunction

	// Random samples: most arrive just after the rate period has run out, some too early
	// to pass the throttle, and a few after a large jump that may wrap the counter.
	task automatic make_random_sample(output o2mcc_pkg::sample_t s);
		int          r;
		logic [31:0] step;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			step = '0;
		end else if (r < 20) begin
			step = $urandom_range(0, throttle_ms);
		end else if (r < 92) begin
			step = throttle_ms + $urandom_range(0, 5);
		end else begin
			step = $urandom;
		end
		gen_time      = gen_time + step;
		s             = gen_prev;
		s.time_ms     = gen_time;
		s.yaw_angle   = next_angle(gen_prev.yaw_angle);
		s.pitch_angle = next_angle(gen_prev.pitch_angle);
		s.roll_angle  = next_angle(gen_prev.roll_angle);
		s.quat_w      = next_quat(gen_prev.quat_w);
		s.quat_x      = next_quat(gen_prev.quat_x);
		s.quat_y      = next_quat(gen_prev.quat_y);
		s.quat_z      = next_quat(gen_prev.quat_z);
		gen_prev      = s;
	endtask

	// Keeps a shallow queue of samples on offer until enough of them have got through the
	// throttle and the change filter. With a hold-off, the receiver stops early on while
	// samples keep coming, so the block backs up and stalls its input.
	task automatic run_random_phase(input bit with_hold_off);
		int                 start;
		bit                 held;
		o2mcc_pkg::sample_t s;
		start = samples_encoded;
		held  = 1'b0;
		while (samples_encoded - start < PHASE_GOAL) begin
			if (pending_samples.size() < 4) begin
				make_random_sample(s);
				pending_samples.push_back(s);
			end
			if (with_hold_off && !held && samples_encoded - start >= 4) begin
				hold_off_requests++;
				held = 1'b1;
			end
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Fourteen-bit Euler with no throttling (a rate above 1000 gives a zero period),
		// top channel, and controllers at the ends of their range. The roll controller
		// wraps when the fine offset is added. The first sample sends every value.
		apply_setting(o2mcc_pkg::MODE_EULER14, 10'd1023, 5'd16, 7'd127, 7'd0, 7'd96);
		queue_sample(32'd5, -32768, 32767, 0, $urandom, $urandom, $urandom, $urandom);
		queue_sample(32'd5, -32768, 32767, 0, $urandom, $urandom, $urandom, $urandom);
		queue_sample(32'd5, -32764, 32767, 0, 0, 0, 0, 0);
		wait_drained();

		// Quaternion mode at a rate of 1 Hz, channel zero, base controller near
		// the top so that the four controllers wrap. Components at and beyond full scale,
		// a throttled sample, and finally a repeat that changes nothing.
		apply_setting(o2mcc_pkg::MODE_QUAT, 10'd1, 5'd0, 7'd126, 7'd0, 7'd0);
		queue_sample(32'd2000, 0, 0, 0, 16384, -16384, 0, 32767);
		queue_sample(32'd2500, 0, 0, 0, 100, 100, 100, 100);
		queue_sample(32'd3000, 0, 0, 0, -32768, 0, 0, 0);
		queue_sample(32'd4000, 0, 0, 0, 0, 0, 0, 0);
		queue_sample(32'd5000, 0, 0, 0, 0, 0, 0, 0);
		wait_drained();

		// Back to fourteen-bit Euler with angles that match the stored values: only the
		// stale fourth slot differs, so the sample is taken without any message. Then a
		// throttled sample, a normal one, and a throttle check across the counter wrap.
		apply_setting(o2mcc_pkg::MODE_EULER14, 10'd100, 5'd17, 7'd16, 7'd17, 7'd18);
		queue_sample(32'd5005, -4, -4, -4, 0, 0, 0, 0);
		queue_sample(32'd5010, 0, 0, 0, 0, 0, 0, 0);
		queue_sample(32'd5015, 0, 0, 0, 0, 0, 0, 0);
		queue_sample(32'hFFFF_FFFA, 1000, -1000, 32767, 0, 0, 0, 0);
		queue_sample(32'd3, -2000, 2000, -32768, 0, 0, 0, 0);
		queue_sample(32'd4, -2000, 2000, -32768, 0, 0, 0, 0);
		wait_drained();

		// Output switched off: samples vanish and leave the state alone.
		apply_setting(o2mcc_pkg::MODE_OFF, 10'd1000, 5'd31, 7'd0, 7'd127, 7'd64);
		queue_sample(32'd50, 123, 456, 789, 1, 2, 3, 4);
		queue_sample(32'd60, -123, -456, -789, -1, -2, -3, -4);
		wait_drained();

		// Seven-bit Euler, throttling off: the extremes of the angle range, then a sample
		// where yaw and pitch move only below the seven-bit step, so only roll changes.
		apply_setting(o2mcc_pkg::MODE_EULER7, 10'd0, 5'd1, 7'd0, 7'd127, 7'd95);
		queue_sample(32'd100, -32768, 32767, -1, 0, 0, 0, 0);
		queue_sample(32'd100, -32257, 32256, 0, 0, 0, 0, 0);
		wait_drained();

		// Random phases, each starting from an idle block with a fresh setting.
		gen_time = 32'd200;
		apply_setting(o2mcc_pkg::MODE_EULER7, 10'd100, 5'($urandom_range(1, 16)),
			7'($urandom), 7'($urandom), 7'($urandom));
		run_random_phase(1'b0);
		wait_drained();

		apply_setting(o2mcc_pkg::MODE_EULER14, 10'($urandom_range(0, 1023)),
			5'($urandom_range(1, 16)), 7'($urandom), 7'($urandom), 7'($urandom));
		run_random_phase(1'b1);
		wait_drained();

		apply_setting(o2mcc_pkg::MODE_QUAT, 10'd1000, 5'($urandom),
			7'($urandom_range(96, 127)), 7'($urandom), 7'($urandom));
		run_random_phase(1'b0);
		wait_drained();

		apply_setting(o2mcc_pkg::mode_t'($urandom_range(1, 3)), 10'($urandom), 5'($urandom),
			7'($urandom), 7'($urandom), 7'($urandom));
		run_random_phase(1'b0);
		wait_drained();

		if (error_count == 0 && cc_expected.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/o2mcc_pkg.sv
rtl/core/o2mcc_period_div.sv
rtl/core/orientation_to_midi_cc_top.sv
bench/tb.sv
